@@ rtl/core/stpc_pkg.sv @@
// shared types, register indexes, status codes and widths of the calibration core
// no dependencies
package stpc_pkg;

  localparam int RAW_W   = 16;
  localparam int DIFF_W  = RAW_W + 1;
  localparam int Y_W     = 11;
  localparam int DY_W    = Y_W + 1;
  localparam int NUM_W   = DIFF_W + DY_W;
  localparam int MAG_W   = 27;
  localparam int DVS_W   = 16;
  localparam int V_W     = 29;
  localparam int IDX_W   = 4;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  localparam logic [IDX_W-1:0] REG_TEMP_CAL0_RAW     = 4'd0;
  localparam logic [IDX_W-1:0] REG_TEMP_CAL1_RAW     = 4'd1;
  localparam logic [IDX_W-1:0] REG_TEMP_CAL0_EIGHTHS = 4'd2;
  localparam logic [IDX_W-1:0] REG_TEMP_CAL1_EIGHTHS = 4'd3;
  localparam logic [IDX_W-1:0] REG_HUM_CAL0_RAW      = 4'd4;
  localparam logic [IDX_W-1:0] REG_HUM_CAL1_RAW      = 4'd5;
  localparam logic [IDX_W-1:0] REG_HUM_CAL0_HALFPCT  = 4'd6;
  localparam logic [IDX_W-1:0] REG_HUM_CAL1_HALFPCT  = 4'd7;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_READY = 2'd1;
  localparam logic [1:0] ST_ZERO_SPAN = 2'd2;
  localparam logic [1:0] ST_CLAMPED   = 2'd3;

  localparam logic kind_HUM = 1'b1;

  localparam logic signed [V_W-1:0] HUM_MAX = 29'sd1000;
  localparam logic signed [V_W-1:0] OUT_MAX = 29'sd32767;
  localparam logic signed [V_W-1:0] OUT_MIN = -29'sd32768;

  typedef struct packed {
    logic                     kind;
    logic [1:0]               status;
    logic [Y_W-1:0]           y0;
    logic signed [NUM_W-1:0]  num;
    logic signed [DIFF_W-1:0] span;
  } stpc_item_t;

endpackage

@@ rtl/core/stpc_front.sv @@
// front end: calibration registers, point selection, ready and span check and product
// depends on stpc_pkg
module stpc_front import stpc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [RAW_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    kind,
  input  logic signed [RAW_W-1:0] raw_sample,
  input  logic                    sample_ready,
  output logic                    push_valid,
  input  logic                    push_ready,
  output stpc_item_t              push_item
);

  logic signed [RAW_W-1:0] temp_cal0_raw, temp_cal1_raw, hum_cal0_raw, hum_cal1_raw;
  logic [9:0]              temp_cal0_eighths, temp_cal1_eighths;
  logic [7:0]              hum_cal0_halfpct, hum_cal1_halfpct;

  logic                     a_vld;
  logic                     a_kind;
  logic [1:0]               a_status;
  logic [Y_W-1:0]           a_y0;
  logic signed [DIFF_W-1:0] a_dx;
  logic signed [DY_W-1:0]   a_dy;
  logic signed [DIFF_W-1:0] a_span;
  logic                     b_vld;
  stpc_item_t               b_item;

  logic signed [RAW_W-1:0]  c0, c1;
  logic [Y_W-1:0]           y0, y1;
  logic signed [DIFF_W-1:0] span_c, dx_c;
  logic signed [DY_W-1:0]   dy_c;
  logic [1:0]               status_c;
  logic                     en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal0_raw     <= '0;
      temp_cal1_raw     <= '0;
      temp_cal0_eighths <= '0;
      temp_cal1_eighths <= '0;
      hum_cal0_raw      <= '0;
      hum_cal1_raw      <= '0;
      hum_cal0_halfpct  <= '0;
      hum_cal1_halfpct  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TEMP_CAL0_RAW:     temp_cal0_raw     <= cfg_data;
        REG_TEMP_CAL1_RAW:     temp_cal1_raw     <= cfg_data;
        REG_TEMP_CAL0_EIGHTHS: temp_cal0_eighths <= cfg_data[9:0];
        REG_TEMP_CAL1_EIGHTHS: temp_cal1_eighths <= cfg_data[9:0];
        REG_HUM_CAL0_RAW:      hum_cal0_raw      <= cfg_data;
        REG_HUM_CAL1_RAW:      hum_cal1_raw      <= cfg_data;
        REG_HUM_CAL0_HALFPCT:  hum_cal0_halfpct  <= cfg_data[7:0];
        REG_HUM_CAL1_HALFPCT:  hum_cal1_halfpct  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // select calibration points; humidity points in 0.1 %RH
  always_comb begin
    if (kind == kind_HUM) begin
      c0 = hum_cal0_raw;
      c1 = hum_cal1_raw;
      y0 = Y_W'(hum_cal0_halfpct[7:1]) * Y_W'(10);
      y1 = Y_W'(hum_cal1_halfpct[7:1]) * Y_W'(10);
    end else begin
      c0 = temp_cal0_raw;
      c1 = temp_cal1_raw;
      y0 = Y_W'(temp_cal0_eighths);
      y1 = Y_W'(temp_cal1_eighths);
    end
    span_c = DIFF_W'(c1) - DIFF_W'(c0);
    dx_c   = DIFF_W'(raw_sample) - DIFF_W'(c0);
    dy_c   = $signed({1'b0, y1}) - $signed({1'b0, y0});
    if (!sample_ready) begin
      status_c = ST_NOT_READY;
    end else if (span_c == '0) begin
      status_c = ST_ZERO_SPAN;
    end else begin
      status_c = ST_OK;
    end
  end

  assign en         = !b_vld || push_ready;
  assign in_ready   = en;
  assign push_valid = b_vld;
  assign push_item  = b_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_kind        <= kind;
      a_status      <= status_c;
      a_y0          <= y0;
      a_dx          <= dx_c;
      a_dy          <= dy_c;
      a_span        <= span_c;
      b_item.kind   <= a_kind;
      b_item.status <= a_status;
      b_item.y0     <= a_y0;
      b_item.num    <= NUM_W'(a_dx) * NUM_W'(a_dy);
      b_item.span   <= a_span;
    end
  end

endmodule

@@ rtl/core/stpc_queue.sv @@
// small item queue between front end and divider back end
// depends on stpc_pkg
module stpc_queue import stpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  stpc_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output stpc_item_t pop_item
);

  stpc_item_t       entries [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr, rd_ptr;
  logic [Q_CW-1:0]  count;
  logic             push, pop;

  assign push_ready = (count != Q_CW'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

@@ rtl/core/stpc_back.sv @@
// back end: signed restoring divider, one quotient bit per stage, offset and saturation
// depends on stpc_pkg
module stpc_back import stpc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    pop_valid,
  output logic                    pop_ready,
  input  stpc_item_t              pop_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [RAW_W-1:0] converted_value,
  output logic [1:0]              result_status
);

  typedef struct packed {
    logic             kind;
    logic [1:0]       status;
    logic             neg;
    logic [Y_W-1:0]   y0;
    logic [DVS_W-1:0] dvs;
    logic [DVS_W-1:0] rem;
    logic [MAG_W-1:0] qd;
  } div_t;

  logic             vld [MAG_W+1];
  div_t             stg [MAG_W+1];
  logic             en;
  logic [NUM_W-1:0] num_abs;
  logic [DIFF_W-1:0] span_abs;

  logic signed [MAG_W:0]  q_s;
  logic signed [V_W-1:0]  v;
  logic signed [RAW_W-1:0] val_c;
  logic [1:0]             st_c;

  function automatic div_t div_step(input div_t s);
    div_t            r;
    logic [DVS_W:0]  trial;
    logic [DVS_W:0]  diff;
    r     = s;
    trial = {s.rem, s.qd[MAG_W-1]};
    diff  = trial - {1'b0, s.dvs};
    if (trial >= {1'b0, s.dvs}) begin
      r.rem = diff[DVS_W-1:0];
      r.qd  = {s.qd[MAG_W-2:0], 1'b1};
    end else begin
      r.rem = trial[DVS_W-1:0];
      r.qd  = {s.qd[MAG_W-2:0], 1'b0};
    end
    return r;
  endfunction

  assign en        = !out_valid || out_ready;
  assign pop_ready = en;

  assign num_abs  = pop_item.num[NUM_W-1] ? NUM_W'(-pop_item.num) : pop_item.num;
  assign span_abs = pop_item.span[DIFF_W-1] ? DIFF_W'(-pop_item.span) : pop_item.span;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0].kind   <= pop_item.kind;
      stg[0].status <= pop_item.status;
      stg[0].neg    <= pop_item.num[NUM_W-1] ^ pop_item.span[DIFF_W-1];
      stg[0].y0     <= pop_item.y0;
      stg[0].dvs    <= span_abs[DVS_W-1:0];
      stg[0].rem    <= '0;
      stg[0].qd     <= num_abs[MAG_W-1:0];
    end
  end

  for (genvar i = 1; i <= MAG_W; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld[i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        stg[i] <= div_step(stg[i-1]);
      end
    end
  end

  always_comb begin
    q_s = stg[MAG_W].neg ? -$signed({1'b0, stg[MAG_W].qd}) : $signed({1'b0, stg[MAG_W].qd});
    v   = V_W'(q_s) + V_W'($signed({1'b0, stg[MAG_W].y0}));
    if (stg[MAG_W].status != ST_OK) begin
      val_c = '0;
      st_c  = stg[MAG_W].status;
    end else if (stg[MAG_W].kind == kind_HUM && v > HUM_MAX) begin
      val_c = RAW_W'(HUM_MAX);
      st_c  = ST_CLAMPED;
    end else if (v > OUT_MAX) begin
      val_c = RAW_W'(OUT_MAX);
      st_c  = ST_CLAMPED;
    end else if (v < OUT_MIN) begin
      val_c = RAW_W'(OUT_MIN);
      st_c  = ST_CLAMPED;
    end else begin
      val_c = v[RAW_W-1:0];
      st_c  = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[MAG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      converted_value <= val_c;
      result_status   <= st_c;
    end
  end

endmodule

@@ rtl/core/sensor_two_point_calibration_core.sv @@
// path to result valid: front end a and b registers, queue, divider registers, output register
// throughput: one sample per cycle if out_ready holds; 27 divider stages, one quotient bit each
// a four entry queue lets the front end keep taking samples while the back end is stalled
// reset (synchronous, active high) clears calibration registers to zero and all valid bits
// top level: front end, queue, divider back end; depends on stpc_pkg
module sensor_two_point_calibration_core import stpc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [RAW_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    kind,
  input  logic signed [RAW_W-1:0] raw_sample,
  input  logic                    sample_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [RAW_W-1:0] converted_value,
  output logic [1:0]              result_status
);

  logic       push_valid, push_ready, pop_valid, pop_ready;
  stpc_item_t push_item, pop_item;

  stpc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .raw_sample   (raw_sample),
    .sample_ready (sample_ready),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  stpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  stpc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_item        (pop_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .converted_value (converted_value),
    .result_status   (result_status)
  );

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_status == ST_NOT_READY || result_status == ST_ZERO_SPAN)
      |-> converted_value == '0)
    else $error("error result with nonzero value");

  a_clamp_val: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_status == ST_CLAMPED
      |-> (converted_value == 16'sd32767 || converted_value == -16'sd32768 ||
           converted_value == 16'sd1000))
    else $error("clamped result not at a limit");

  a_queue_flow: assert property (@(posedge clk) disable iff (rst)
    !pop_valid && !push_valid |=> !pop_valid)
    else $error("queue produced an item with nothing pushed");
`endif

endmodule

@@ bench/testbench.sv @@
// testbench for sensor_two_point_calibration_core: directed and random samples under random stalls,
// each result checked against an in-bench interpolation predictor; depends on stpc_pkg
module testbench;
  import stpc_pkg::*;

  localparam logic KIND_TEMP    = ~kind_HUM;
  localparam int   NUM_CAL_REGS = 8;
  localparam int   HOLD_CYCLES  = 400;
  localparam int   STALL_LIMIT  = 3000;
  localparam int   DRAIN_CYCLES = 64;

  typedef struct packed {
    logic signed [RAW_W-1:0] value;
    logic [1:0]              status;
  } reading_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [IDX_W-1:0]        cfg_index;
  logic [RAW_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic                    kind;
  logic signed [RAW_W-1:0] raw_sample;
  logic                    sample_ready;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [RAW_W-1:0] converted_value;
  logic [1:0]              result_status;

  logic [RAW_W-1:0] cal_regs [2**IDX_W];
  reading_t         expected_readings [$];
  int               mismatch_count = 0;
  int               stall_count = 0;
  bit               calm = 1'b0;
  bit               quiet = 1'b0;
  bit               hold_req = 1'b0;

  sensor_two_point_calibration_core uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .raw_sample      (raw_sample),
    .sample_ready    (sample_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .converted_value (converted_value),
    .result_status   (result_status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic reading_t predict_reading(input logic k, input logic [RAW_W-1:0] raw,
                                               input logic rdy);
    longint   c0, c1, y0, y1, span, v;
    reading_t r;
    r.value  = '0;
    r.status = ST_OK;
    if (!rdy) begin
      r.status = ST_NOT_READY;
      return r;
    end
    if (k == kind_HUM) begin
      c0 = longint'($signed(cal_regs[REG_HUM_CAL0_RAW]));
      c1 = longint'($signed(cal_regs[REG_HUM_CAL1_RAW]));
      y0 = longint'(cal_regs[REG_HUM_CAL0_HALFPCT][7:1]) * 10;
      y1 = longint'(cal_regs[REG_HUM_CAL1_HALFPCT][7:1]) * 10;
    end else begin
      c0 = longint'($signed(cal_regs[REG_TEMP_CAL0_RAW]));
      c1 = longint'($signed(cal_regs[REG_TEMP_CAL1_RAW]));
      y0 = longint'(cal_regs[REG_TEMP_CAL0_EIGHTHS][9:0]);
      y1 = longint'(cal_regs[REG_TEMP_CAL1_EIGHTHS][9:0]);
    end
    span = c1 - c0;
    if (span == 0) begin
      r.status = ST_ZERO_SPAN;
      return r;
    end
    v = y0 + ((longint'($signed(raw)) - c0) * (y1 - y0)) / span;
    if (k == kind_HUM && v > longint'(HUM_MAX)) begin
      v = longint'(HUM_MAX);
      r.status = ST_CLAMPED;
    end else if (v > longint'(OUT_MAX)) begin
      v = longint'(OUT_MAX);
      r.status = ST_CLAMPED;
    end else if (v < longint'(OUT_MIN)) begin
      v = longint'(OUT_MIN);
      r.status = ST_CLAMPED;
    end
    r.value = RAW_W'(v);
    return r;
  endfunction

  task automatic send_sample(input logic k, input logic [RAW_W-1:0] raw, input logic rdy);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    raw_sample   <= raw;
    sample_ready <= rdy;
    do @(posedge clk); while (!in_ready);
    expected_readings.push_back(predict_reading(k, raw, rdy));
  endtask

  task automatic drain_readings();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [RAW_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TEMP_CAL0_EIGHTHS, REG_TEMP_CAL1_EIGHTHS: cal_regs[idx] = data & 16'h03ff;
      REG_HUM_CAL0_HALFPCT, REG_HUM_CAL1_HALFPCT:   cal_regs[idx] = data & 16'h00ff;
      default: if (idx < NUM_CAL_REGS) cal_regs[idx] = data;
    endcase
  endtask

  // every setting also carries a write to an unused index, which must change nothing
  task automatic set_cal(input logic [RAW_W-1:0] t0_raw, t1_raw, t0, t1,
                         input logic [RAW_W-1:0] h0_raw, h1_raw, h0, h1);
    drain_readings();
    write_reg(REG_TEMP_CAL0_RAW, t0_raw);
    write_reg(REG_TEMP_CAL1_RAW, t1_raw);
    write_reg(REG_TEMP_CAL0_EIGHTHS, t0);
    write_reg(REG_TEMP_CAL1_EIGHTHS, t1);
    write_reg(REG_HUM_CAL0_RAW, h0_raw);
    write_reg(REG_HUM_CAL1_RAW, h1_raw);
    write_reg(REG_HUM_CAL0_HALFPCT, h0);
    write_reg(REG_HUM_CAL1_HALFPCT, h1);
    write_reg(IDX_W'(NUM_CAL_REGS + $urandom_range(0, 7)), RAW_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [2*RAW_W-1:0] cal_pair();
    logic [RAW_W-1:0] a, b;
    a = RAW_W'($urandom);
    case ($urandom_range(0, 9))
      0: b = a;
      1: begin
        a = 16'h8000;
        b = 16'h7fff;
      end
      2: begin
        a = 16'h7fff;
        b = 16'h8000;
      end
      3, 4, 5: b = RAW_W'($urandom);
      default: b = a + RAW_W'($urandom_range(0, 400)) - 16'd200;
    endcase
    return {a, b};
  endfunction

  task automatic random_cal();
    logic [2*RAW_W-1:0] tp, hp;
    logic [RAW_W-1:0]   lv [4];
    tp = cal_pair();
    hp = cal_pair();
    foreach (lv[i]) begin
      case ($urandom_range(0, 5))
        0: lv[i] = '0;
        1: lv[i] = '1;
        default: lv[i] = RAW_W'($urandom);
      endcase
    end
    set_cal(tp[2*RAW_W-1:RAW_W], tp[RAW_W-1:0], lv[0], lv[1],
            hp[2*RAW_W-1:RAW_W], hp[RAW_W-1:0], lv[2], lv[3]);
  endtask

  // mostly samples near the first calibration point so results land in range
  task automatic send_random_sample();
    logic             k;
    logic [RAW_W-1:0] base, raw;
    k    = logic'($urandom_range(0, 1));
    base = (k == kind_HUM) ? cal_regs[REG_HUM_CAL0_RAW] : cal_regs[REG_TEMP_CAL0_RAW];
    case ($urandom_range(0, 7))
      0: raw = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      1, 2: raw = RAW_W'($urandom);
      default: raw = base + RAW_W'($urandom_range(0, 1023)) - 16'd512;
    endcase
    send_sample(k, raw, $urandom_range(0, 9) != 0);
  endtask

  task automatic test_reset_state();
    send_sample(KIND_TEMP, 16'h0000, 1'b1);
    send_sample(kind_HUM, 16'h7fff, 1'b1);
    send_sample(KIND_TEMP, 16'h1234, 1'b0);
    send_sample(kind_HUM, 16'h8000, 1'b0);
  endtask

  task automatic test_endpoints();
    set_cal(16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h8000, 16'h7fff, 16'h0000, 16'hffff);
    send_sample(KIND_TEMP, 16'h8000, 1'b1);
    send_sample(KIND_TEMP, 16'h7fff, 1'b1);
    send_sample(KIND_TEMP, 16'h0000, 1'b1);
    send_sample(KIND_TEMP, 16'h1234, 1'b1);
    send_sample(kind_HUM, 16'h8000, 1'b1);
    send_sample(kind_HUM, 16'h7fff, 1'b1);
    send_sample(kind_HUM, 16'h0000, 1'b1);
    send_sample(kind_HUM, 16'hffff, 1'b0);
  endtask

  task automatic test_saturation();
    set_cal(16'h0000, 16'h0001, 16'h0000, 16'h03ff, 16'h0000, 16'h0001, 16'h0000, 16'h00ff);
    send_sample(KIND_TEMP, 16'h7fff, 1'b1);
    send_sample(KIND_TEMP, 16'h8000, 1'b1);
    send_sample(KIND_TEMP, 16'hffff, 1'b1);
    send_sample(kind_HUM, 16'h0001, 1'b1);
    send_sample(kind_HUM, 16'h8000, 1'b1);
    send_sample(kind_HUM, 16'h0000, 1'b1);
  endtask

  // negative spans and slopes with remainders: quotient truncates toward zero
  task automatic test_truncation();
    set_cal(16'd100, 16'd97, 16'd800, 16'd16, 16'd300, 16'd303, 16'd200, 16'd9);
    send_sample(KIND_TEMP, 16'd101, 1'b1);
    send_sample(KIND_TEMP, 16'd99, 1'b1);
    send_sample(kind_HUM, 16'd301, 1'b1);
    send_sample(kind_HUM, 16'd299, 1'b1);
    send_sample(kind_HUM, 16'd302, 1'b1);
  endtask

  task automatic test_random_settings();
    repeat (8) begin
      random_cal();
      calm  = ($urandom_range(0, 3) == 0);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (150) send_random_sample();
    end
    calm  = 1'b0;
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    random_cal();
    calm     = 1'b1;
    hold_req = 1'b1;
    repeat (120) send_random_sample();
    calm = 1'b0;
  endtask

  task automatic test_streaming();
    calm  = 1'b1;
    quiet = 1'b1;
    random_cal();
    repeat (250) send_random_sample();
  endtask

  initial begin : sink
    int n;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result: expected none, actual value %0d status %0d",
                 $time, converted_value, result_status);
      end else begin
        want = expected_readings.pop_front();
        if (converted_value !== want.value) begin
          mismatch_count++;
          $display("%0t converted_value mismatch: expected %0d actual %0d",
                   $time, want.value, converted_value);
        end
        if (result_status !== want.status) begin
          mismatch_count++;
          $display("%0t result_status mismatch: expected %0d actual %0d",
                   $time, want.status, result_status);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_count <= 0;
    end else if (stall_count == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    rst          <= 1'b1;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    kind         <= KIND_TEMP;
    raw_sample   <= '0;
    sample_ready <= 1'b0;
    foreach (cal_regs[i]) cal_regs[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_endpoints();
    test_saturation();
    test_truncation();
    test_random_settings();
    test_backpressure();
    test_streaming();
    drain_readings();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
